### rtl/gnc_pkg.sv
// shared constants, types and codes of the grid neighbour counter
package gnc_pkg;

  localparam int unsigned MaxRows  = 64;
  localparam int unsigned MaxCols  = 64;
  localparam int unsigned RowW     = $clog2(MaxRows);
  localparam int unsigned ColW     = $clog2(MaxCols);
  localparam int unsigned AddrW    = RowW + ColW;
  localparam int unsigned SizeW    = 7;
  localparam int unsigned CountW   = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgRows = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCols = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgKind = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgWrap = 2'd3;

  // reset values of the registers
  localparam logic [SizeW-1:0] RowsReset = SizeW'(MaxRows);
  localparam logic [SizeW-1:0] ColsReset = SizeW'(MaxCols);

  // item function codes
  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  // neighbourhood codes
  localparam logic KindMoore      = 1'b0;
  localparam logic KindVonNeumann = 1'b1;

  // neighbour directions, orthogonal ones first so von neumann stops at dir_rt
  typedef enum logic [2:0] {
    DirUp,
    DirDn,
    DirLf,
    DirRt,
    DirUpRt,
    DirUpLf,
    DirDnRt,
    DirDnLf
  } nbr_dir_e;

  typedef enum logic [1:0] {
    SeqIdle,
    SeqCalc,
    SeqDrain,
    SeqDone
  } seq_state_e;

  // clamped grid geometry and mode
  typedef struct packed {
    logic [SizeW-1:0] rows;
    logic [SizeW-1:0] cols;
    logic             kind;
    logic             wrap;
  } grid_cfg_t;

  // request to the neighbour address unit
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    nbr_dir_e        dir;
  } nbr_req_t;

  // neighbour coordinates and whether the cell lies on the grid
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            hit;
  } nbr_addr_t;

endpackage

### rtl/gnc_if.sv
// item and result channels of the grid neighbour counter
interface gnc_in_if;
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [gnc_pkg::RowW-1:0] row_index;
  logic [gnc_pkg::ColW-1:0] col_index;
  logic                    cell_alive;

  modport source (output valid, func, row_index, col_index, cell_alive, input ready);
  modport sink   (input valid, func, row_index, col_index, cell_alive, output ready);
endinterface

interface gnc_out_if;
  logic                      valid;
  logic                      ready;
  logic [gnc_pkg::CountW-1:0] live_count;
  logic                      bad_position;

  modport source (output valid, live_count, bad_position, input ready);
  modport sink   (input valid, live_count, bad_position, output ready);
endinterface

### rtl/gnc_grid_mem.sv
// single-port cell grid memory with registered read data
module gnc_grid_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [gnc_pkg::AddrW-1:0] addr_i,
  input  logic                      wdata_i,
  output logic                      rdata_o
);
  import gnc_pkg::*;

  localparam int unsigned Depth = MaxRows * MaxCols;

  logic mem_q [Depth];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/gnc_nbr_addr.sv
// neighbour address unit: one step in one direction, wrapped or flat
module gnc_nbr_addr (
  input  gnc_pkg::grid_cfg_t cfg_i,
  input  gnc_pkg::nbr_req_t  req_i,
  output gnc_pkg::nbr_addr_t addr_o
);
  import gnc_pkg::*;

  logic            row_first, row_last, col_first, col_last;
  logic [RowW-1:0] row_up, row_dn;
  logic [ColW-1:0] col_lf, col_rt;
  logic            up_ok, dn_ok, lf_ok, rt_ok;
  logic [SizeW-1:0] last_row, last_col;

  always_comb begin
    last_row  = cfg_i.rows - SizeW'(1);
    last_col  = cfg_i.cols - SizeW'(1);
    row_first = (req_i.row == '0);
    col_first = (req_i.col == '0);
    row_last  = (SizeW'(req_i.row) == last_row);
    col_last  = (SizeW'(req_i.col) == last_col);

    row_up = row_first ? last_row[RowW-1:0] : req_i.row - RowW'(1);
    row_dn = row_last  ? '0                 : req_i.row + RowW'(1);
    col_lf = col_first ? last_col[ColW-1:0] : req_i.col - ColW'(1);
    col_rt = col_last  ? '0                 : req_i.col + ColW'(1);

    // flat edges drop cells beyond the border
    up_ok = cfg_i.wrap | ~row_first;
    dn_ok = cfg_i.wrap | ~row_last;
    lf_ok = cfg_i.wrap | ~col_first;
    rt_ok = cfg_i.wrap | ~col_last;

    addr_o.row = req_i.row;
    addr_o.col = req_i.col;
    addr_o.hit = 1'b0;
    case (req_i.dir)
      DirUp:   begin addr_o.row = row_up; addr_o.hit = up_ok; end
      DirDn:   begin addr_o.row = row_dn; addr_o.hit = dn_ok; end
      DirLf:   begin addr_o.col = col_lf; addr_o.hit = lf_ok; end
      DirRt:   begin addr_o.col = col_rt; addr_o.hit = rt_ok; end
      DirUpRt: begin
        addr_o.row = row_up; addr_o.col = col_rt; addr_o.hit = up_ok & rt_ok;
      end
      DirUpLf: begin
        addr_o.row = row_up; addr_o.col = col_lf; addr_o.hit = up_ok & lf_ok;
      end
      DirDnRt: begin
        addr_o.row = row_dn; addr_o.col = col_rt; addr_o.hit = dn_ok & rt_ok;
      end
      DirDnLf: begin
        addr_o.row = row_dn; addr_o.col = col_lf; addr_o.hit = dn_ok & lf_ok;
      end
      default: addr_o.hit = 1'b0;
    endcase
  end

endmodule

### rtl/gnc_seq.sv
// query sequencer: walks the neighbours, accumulates the count, holds the result
module gnc_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gnc_pkg::grid_cfg_t cfg_i,
  gnc_in_if.sink             item_i,
  gnc_out_if.source          result_o
);
  import gnc_pkg::*;

  seq_state_e        state_q, state_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [ColW-1:0]   col_q, col_d;
  nbr_dir_e          dir_q, dir_d;
  logic              pend_q, pend_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              bad_q, bad_d;
  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] out_cnt_q, out_cnt_d;
  logic              out_bad_q, out_bad_d;

  nbr_req_t          req;
  nbr_addr_t         nbr;
  logic              mem_we, mem_rdata, last_dir, accept, query_bad;
  logic [AddrW-1:0]  mem_addr;

  assign req.row = row_q;
  assign req.col = col_q;
  assign req.dir = dir_q;

  gnc_nbr_addr u_nbr_addr (
    .cfg_i  (cfg_i),
    .req_i  (req),
    .addr_o (nbr)
  );

  gnc_grid_mem u_grid_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (item_i.cell_alive),
    .rdata_o (mem_rdata)
  );

  assign item_i.ready      = (state_q == SeqIdle);
  assign accept            = item_i.valid & item_i.ready;
  assign mem_we            = accept & (item_i.func == FuncWrite);
  assign mem_addr          = mem_we ? {item_i.row_index, item_i.col_index}
                                    : {nbr.row, nbr.col};
  assign query_bad         = (SizeW'(item_i.row_index) >= cfg_i.rows) |
                             (SizeW'(item_i.col_index) >= cfg_i.cols);
  assign last_dir          = (dir_q == DirDnLf) |
                             ((cfg_i.kind == KindVonNeumann) & (dir_q == DirRt));

  assign result_o.valid        = out_valid_q;
  assign result_o.live_count   = out_cnt_q;
  assign result_o.bad_position = out_bad_q;

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    dir_d       = dir_q;
    pend_d      = 1'b0;
    cnt_d       = cnt_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q & ~result_o.ready;
    out_cnt_d   = out_cnt_q;
    out_bad_d   = out_bad_q;

    case (state_q)
      SeqIdle: begin
        if (accept && item_i.func == FuncQuery) begin
          row_d   = item_i.row_index;
          col_d   = item_i.col_index;
          dir_d   = DirUp;
          cnt_d   = '0;
          bad_d   = query_bad;
          state_d = query_bad ? SeqDone : SeqCalc;
        end
      end
      SeqCalc: begin
        // issue one read, add the one from the cycle before
        pend_d = nbr.hit;
        cnt_d  = cnt_q + CountW'(pend_q & mem_rdata);
        dir_d  = nbr_dir_e'(3'(dir_q + 3'd1));
        if (last_dir) begin
          state_d = SeqDrain;
        end
      end
      SeqDrain: begin
        cnt_d   = cnt_q + CountW'(pend_q & mem_rdata);
        state_d = SeqDone;
      end
      SeqDone: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_cnt_d   = cnt_q;
          out_bad_d   = bad_q;
          state_d     = SeqIdle;
        end
      end
      default: state_d = SeqIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SeqIdle;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q     <= row_d;
    col_q     <= col_d;
    dir_q     <= dir_d;
    cnt_q     <= cnt_d;
    bad_q     <= bad_d;
    out_cnt_q <= out_cnt_d;
    out_bad_q <= out_bad_d;
  end

endmodule

### rtl/grid_neighbour_count.sv
// top level of the grid neighbour counter: configuration registers and sequencer
// Keeps a 64 x 64 grid of one-bit cells in a single-port memory. A write
// transaction (func 0) stores one cell and gives no result; a query
// transaction (func 1) returns the number of live neighbours of the named
// cell, Moore (8) or von Neumann (4), with toroidal or flat edges. The
// neighbours are read one per cycle through the single memory port, then a
// drain state adds the last read and a done state passes the count to the
// output register; a query outside the grid in use skips the reads and
// returns count 0 with bad_position set. The input is not ready while a
// query is at work. The result sits in an output register, so a stalled
// result only holds the block once the next query is done. Rows and
// columns in use are clamped to 1..64. Querying a cell that was never
// written gives an undefined count. Configuration writes take effect at once
// and should only be made while no transaction is in flight.
module grid_neighbour_count (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gnc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gnc_pkg::CfgDataW-1:0] cfg_data_i,
  gnc_in_if.sink                       item_i,
  gnc_out_if.source                    result_o
);
  import gnc_pkg::*;

  // raw register contents, as written
  logic [SizeW-1:0] rows_q, cols_q;
  logic             kind_q, wrap_q;
  grid_cfg_t        cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RowsReset;
      cols_q <= ColsReset;
      kind_q <= KindMoore;
      wrap_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRows: rows_q <= cfg_data_i[SizeW-1:0];
        CfgCols: cols_q <= cfg_data_i[SizeW-1:0];
        CfgKind: kind_q <= cfg_data_i[0];
        CfgWrap: wrap_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamp the sizes in use, zero acts as one
  always_comb begin
    cfg.rows = rows_q;
    if (rows_q == '0) begin
      cfg.rows = SizeW'(1);
    end else if (rows_q > SizeW'(MaxRows)) begin
      cfg.rows = SizeW'(MaxRows);
    end
    cfg.cols = cols_q;
    if (cols_q == '0) begin
      cfg.cols = SizeW'(1);
    end else if (cols_q > SizeW'(MaxCols)) begin
      cfg.cols = SizeW'(MaxCols);
    end
    cfg.kind = kind_q;
    cfg.wrap = wrap_q;
  end

  // sequencer with the grid memory and the neighbour address unit
  gnc_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (item_i),
    .result_o (result_o)
  );

endmodule

### bench/tb_top.sv
// testbench of the grid neighbour counter: stimulus, neighbour predictor and result checks
module tb_top;
  import gnc_pkg::*;

  // edge modes of the grid as written to the wrap register
  localparam logic EdgeFlat = 1'b0;
  localparam logic EdgeWrap = 1'b1;

  // whether a directed row carries a hand-written result
  localparam logic Typed     = 1'b1;
  localparam logic Predicted = 1'b0;

  localparam int unsigned SettleCycles   = 16;      // longer than the slowest query
  localparam int unsigned LongHoldCycles = 300;     // receiver hold-off that backs up the block
  localparam int unsigned RandomPhases   = 10;
  localparam int unsigned ItemsPerPhase  = 28;
  localparam int unsigned CycleLimit     = 500_000;
  localparam int unsigned ProbeCount     = 25;
  // lines written before any query: the first FillEdge ones and the last two
  localparam int          FillEdge       = 8;
  localparam int          FillLines      = FillEdge + 2;

  // one count result as it leaves the block
  typedef struct packed {
    logic [CountW-1:0] count;
    logic              bad;
  } tally_t;

  // one row of the directed table: grid setting, the transaction and an optional answer
  typedef struct packed {
    logic [SizeW-1:0]  rows;
    logic [SizeW-1:0]  cols;
    logic              kind;
    logic              wrap;
    logic              func;
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    logic              alive;
    logic              typed;
    logic [CountW-1:0] count;
    logic              bad;
  } probe_t;

  // directed part: ring of live cells around the origin, then every edge mode,
  // both neighbourhoods, clamped sizes, one-cell and two-cell tori and queries off the grid
  localparam probe_t Probes [ProbeCount] = '{
    // live ring around (0,0) on the full torus, origin itself alive too
    '{7'd64, 7'd64, KindMoore, EdgeWrap, FuncWrite, 6'd63, 6'd63, 1'b1, Predicted, 4'd0, 1'b0},
    '{7'd64, 7'd64, KindMoore, EdgeWrap, FuncWrite, 6'd63, 6'd0,  1'b1, Predicted, 4'd0, 1'b0},
    '{7'd64, 7'd64, KindMoore, EdgeWrap, FuncWrite, 6'd63, 6'd1,  1'b1, Predicted, 4'd0, 1'b0},
    '{7'd64, 7'd64, KindMoore, EdgeWrap, FuncWrite, 6'd0,  6'd63, 1'b1, Predicted, 4'd0, 1'b0},
    '{7'd64, 7'd64, KindMoore, EdgeWrap, FuncWrite, 6'd0,  6'd1,  1'b1, Predicted, 4'd0, 1'b0},
    '{7'd64, 7'd64, KindMoore, EdgeWrap, FuncWrite, 6'd1,  6'd63, 1'b1, Predicted, 4'd0, 1'b0},
    '{7'd64, 7'd64, KindMoore, EdgeWrap, FuncWrite, 6'd1,  6'd0,  1'b1, Predicted, 4'd0, 1'b0},
    '{7'd64, 7'd64, KindMoore, EdgeWrap, FuncWrite, 6'd1,  6'd1,  1'b1, Predicted, 4'd0, 1'b0},
    '{7'd64, 7'd64, KindMoore, EdgeWrap, FuncWrite, 6'd0,  6'd0,  1'b1, Predicted, 4'd0, 1'b0},
    // full ring seen through the wrapped corner
    '{7'd64, 7'd64, KindMoore, EdgeWrap, FuncQuery, 6'd0,  6'd0,  1'b0, Typed,     4'd8, 1'b0},
    // flat corner keeps three, four orthogonal on the torus, two when flat
    '{7'd64, 7'd64, KindMoore, EdgeFlat, FuncQuery, 6'd0,  6'd0,  1'b0, Typed,     4'd3, 1'b0},
    '{7'd64, 7'd64, KindVonNeumann, EdgeFlat, FuncQuery, 6'd0, 6'd0, 1'b0, Typed,  4'd2, 1'b0},
    '{7'd64, 7'd64, KindVonNeumann, EdgeWrap, FuncQuery, 6'd0, 6'd0, 1'b0, Typed,  4'd4, 1'b0},
    // zero rows acts as one: a one-cell torus counts its own live cell eight times
    '{7'd0,  7'd1,  KindMoore, EdgeWrap, FuncQuery, 6'd0,  6'd0,  1'b0, Typed,     4'd8, 1'b0},
    '{7'd0,  7'd1,  KindMoore, EdgeFlat, FuncQuery, 6'd0,  6'd0,  1'b0, Typed,     4'd0, 1'b0},
    // queries off a one-cell grid
    '{7'd1,  7'd1,  KindMoore, EdgeFlat, FuncQuery, 6'd0,  6'd1,  1'b0, Typed,     4'd0, 1'b1},
    '{7'd1,  7'd1,  KindMoore, EdgeFlat, FuncQuery, 6'd63, 6'd63, 1'b0, Typed,     4'd0, 1'b1},
    // two-by-two torus: every neighbour is live and seen twice or four times
    '{7'd2,  7'd2,  KindMoore, EdgeWrap, FuncQuery, 6'd1,  6'd1,  1'b0, Typed,     4'd8, 1'b0},
    // oversized registers clamp to the full grid
    '{7'd127, 7'd127, KindMoore, EdgeWrap, FuncQuery, 6'd63, 6'd63, 1'b0, Predicted, 4'd0, 1'b0},
    '{7'd127, 7'd127, KindMoore, EdgeFlat, FuncQuery, 6'd63, 6'd63, 1'b0, Predicted, 4'd0, 1'b0},
    '{7'd127, 7'd127, KindVonNeumann, EdgeFlat, FuncQuery, 6'd63, 6'd0, 1'b0, Predicted, 4'd0,
      1'b0},
    // kill one ring cell and the wrapped corner drops to seven
    '{7'd64, 7'd64, KindMoore, EdgeWrap, FuncWrite, 6'd63, 6'd63, 1'b0, Predicted, 4'd0, 1'b0},
    '{7'd64, 7'd64, KindMoore, EdgeWrap, FuncQuery, 6'd0,  6'd0,  1'b0, Typed,     4'd7, 1'b0},
    // narrow torus, then a column just past its edge
    '{7'd64, 7'd3,  KindVonNeumann, EdgeWrap, FuncQuery, 6'd5, 6'd2, 1'b0, Predicted, 4'd0, 1'b0},
    '{7'd64, 7'd3,  KindMoore, EdgeWrap, FuncQuery, 6'd0,  6'd3,  1'b0, Typed,     4'd0, 1'b1}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  gnc_in_if  item_bus ();
  gnc_out_if result_bus ();

  // shadow of the block: grid contents and register values as last written
  bit               grid_model [MaxRows][MaxCols];
  logic [SizeW-1:0] rows_cfg;
  logic [SizeW-1:0] cols_cfg;
  logic             kind_cfg;
  logic             wrap_cfg;

  // counts still owed by the block, oldest first
  tally_t pending_tallies [$];
  tally_t oldest_tally;

  int unsigned cycle_count     = 0;
  int unsigned fail_count      = 0;
  int unsigned items_sent      = 0;
  int unsigned queries_checked = 0;
  int unsigned settings_used   = 0;
  int unsigned hold_left       = 0;
  bit          long_hold_req   = 1'b0;
  bit          quiet           = 1'b0;   // no idling on either side

  grid_neighbour_count dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .item_i     (item_bus),
    .result_o   (result_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // live neighbours of (r, c) under the current setting, or the off-grid answer
  function automatic tally_t predict_tally(int r, int c);
    int     nr;
    int     nc;
    int     up;
    int     dn;
    int     lf;
    int     rt;
    int     sum;
    bit     moore;
    bit     has_up;
    bit     has_dn;
    bit     has_lf;
    bit     has_rt;
    tally_t t;
    // zero acts as one, anything past the physical grid as the full grid
    nr = (rows_cfg == 0) ? 1 : (rows_cfg > MaxRows) ? MaxRows : int'(rows_cfg);
    nc = (cols_cfg == 0) ? 1 : (cols_cfg > MaxCols) ? MaxCols : int'(cols_cfg);
    moore = (kind_cfg == KindMoore);
    sum = 0;
    t.bad = 1'b0;
    if (r >= nr || c >= nc) begin
      t.bad = 1'b1;
    end else if (wrap_cfg == EdgeWrap) begin
      // torus: on tiny grids the same cell may be seen more than once, even the cell itself
      up = (r + nr - 1) % nr;
      dn = (r + 1) % nr;
      lf = (c + nc - 1) % nc;
      rt = (c + 1) % nc;
      sum = sum + grid_model[up][c] + grid_model[dn][c] + grid_model[r][lf] + grid_model[r][rt];
      if (moore) begin
        sum = sum + grid_model[up][rt] + grid_model[up][lf] + grid_model[dn][rt]
              + grid_model[dn][lf];
      end
    end else begin
      // flat: neighbours beyond the edge of the grid in use are not there
      has_up = (r != 0);
      has_dn = (r != nr - 1);
      has_lf = (c != 0);
      has_rt = (c != nc - 1);
      if (has_up) sum = sum + grid_model[r-1][c];
      if (has_dn) sum = sum + grid_model[r+1][c];
      if (has_lf) sum = sum + grid_model[r][c-1];
      if (has_rt) sum = sum + grid_model[r][c+1];
      if (moore) begin
        if (has_up && has_rt) sum = sum + grid_model[r-1][c+1];
        if (has_up && has_lf) sum = sum + grid_model[r-1][c-1];
        if (has_dn && has_rt) sum = sum + grid_model[r+1][c+1];
        if (has_dn && has_lf) sum = sum + grid_model[r+1][c-1];
      end
    end
    t.count = CountW'(sum);
    return t;
  endfunction

  // offer one transaction, wait for it to be taken, then record what it does
  task automatic deliver(input logic func, input logic [RowW-1:0] r, input logic [ColW-1:0] c,
                         input logic alive, input logic typed, input tally_t typed_tally);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    item_bus.valid      <= 1'b1;
    item_bus.func       <= func;
    item_bus.row_index  <= r;
    item_bus.col_index  <= c;
    item_bus.cell_alive <= alive;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    items_sent++;
    if (func == FuncWrite) begin
      grid_model[r][c] = alive;
    end else if (typed) begin
      pending_tallies.push_back(typed_tally);
    end else begin
      pending_tallies.push_back(predict_tally(r, c));
    end
  endtask

  // stop offering, let every owed count come back, then give a trailing write time to land
  task automatic settle();
    item_bus.valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one register write per clock, all four registers, only while the block is idle
  task automatic apply_setting(input logic [SizeW-1:0] rows, input logic [SizeW-1:0] cols,
                               input logic kind, input logic wrap);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgRows;
    cfg_data <= rows;
    @(posedge clk_i);
    cfg_idx  <= CfgCols;
    cfg_data <= cols;
    @(posedge clk_i);
    cfg_idx  <= CfgKind;
    cfg_data <= CfgDataW'(kind);
    @(posedge clk_i);
    cfg_idx  <= CfgWrap;
    cfg_data <= CfgDataW'(wrap);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    rows_cfg = rows;
    cols_cfg = cols;
    kind_cfg = kind;
    wrap_cfg = wrap;
    settings_used++;
  endtask

  // sizes lean to the extremes: zero, tiny tori, the full grid and oversized values
  function automatic logic [SizeW-1:0] pick_size();
    logic [SizeW-1:0] s;
    case ($urandom_range(0, 6))
      0: begin
        s = 7'd0;
      end
      1: begin
        s = 7'd1;
      end
      2: begin
        s = SizeW'($urandom_range(2, 3));
      end
      3: begin
        s = 7'd64;
      end
      4: begin
        s = SizeW'($urandom_range(65, 127));
      end
      default: begin
        s = SizeW'($urandom_range(1, 64));
      end
    endcase
    return s;
  endfunction

  // index of the i-th filled line: the first FillEdge lines, then the last two
  function automatic int fill_line(int i, int maxn);
    return (i < FillEdge) ? i : maxn - FillLines + i;
  endfunction

  // coordinate on a line of n in use whose query reads only filled lines, now and then off it
  function automatic int pick_coord(int n, int maxn);
    int k;
    if (n < maxn && $urandom_range(0, 4) == 0) begin
      k = int'($urandom_range(n, maxn - 1));
    end else if (n <= FillEdge) begin
      k = int'($urandom_range(0, n - 1));
    end else if (n == maxn) begin
      // full size: the low lines and the last one, whose wrap reaches the first
      k = int'($urandom_range(0, FillEdge - 1));
      if (k == FillEdge - 1) k = maxn - 1;
    end else begin
      // other sizes: stay inside the low lines so no wrap reaches an unfilled one
      k = int'($urandom_range(1, FillEdge - 2));
    end
    return k;
  endfunction

  // result side: check each result against the oldest owed count, then pick next ready
  always @(posedge clk_i) begin
    if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      if (pending_tallies.size() == 0) begin
        $error("result with nothing owed: live_count %0d bad_position %0d",
               result_bus.live_count, result_bus.bad_position);
        fail_count++;
      end else begin
        oldest_tally = pending_tallies.pop_front();
        queries_checked++;
        if (result_bus.live_count !== oldest_tally.count) begin
          $error("live_count: expected %0d, got %0d", oldest_tally.count,
                 result_bus.live_count);
          fail_count++;
        end
        if (result_bus.bad_position !== oldest_tally.bad) begin
          $error("bad_position: expected %0d, got %0d", oldest_tally.bad,
                 result_bus.bad_position);
          fail_count++;
        end
      end
    end
    // long hold-off first, then random short stalls, none once the run goes quiet
    if (hold_left > 0) begin
      hold_left--;
      result_bus.ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LongHoldCycles - 1;
      result_bus.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(0, 9);
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("grid_neighbour_count regression: fail");
    $finish;
  end

  initial begin
    tally_t           none;
    tally_t           want;
    logic             func;
    logic [RowW-1:0]  r;
    logic [ColW-1:0]  c;
    int               nr;
    int               nc;

    none = '0;
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CfgRows;
    cfg_data            <= '0;
    item_bus.valid      <= 1'b0;
    item_bus.func       <= FuncWrite;
    item_bus.row_index  <= '0;
    item_bus.col_index  <= '0;
    item_bus.cell_alive <= 1'b0;
    rows_cfg = RowsReset;
    cols_cfg = ColsReset;
    kind_cfg = KindMoore;
    wrap_cfg = EdgeWrap;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // cells are undefined until written: fill every cell that any later query can read
    for (int i = 0; i < FillLines; i++) begin
      for (int j = 0; j < FillLines; j++) begin
        deliver(FuncWrite, RowW'(fill_line(i, int'(MaxRows))),
                ColW'(fill_line(j, int'(MaxCols))), logic'($urandom_range(0, 1)),
                Predicted, none);
      end
    end

    // directed table: a changed setting is written between rows once the block is idle
    for (int i = 0; i < ProbeCount; i++) begin
      if (Probes[i].rows != rows_cfg || Probes[i].cols != cols_cfg ||
          Probes[i].kind != kind_cfg || Probes[i].wrap != wrap_cfg) begin
        apply_setting(Probes[i].rows, Probes[i].cols, Probes[i].kind, Probes[i].wrap);
      end
      want.count = Probes[i].count;
      want.bad   = Probes[i].bad;
      deliver(Probes[i].func, Probes[i].row, Probes[i].col, Probes[i].alive,
              Probes[i].typed, want);
    end

    // random phases, each under a fresh setting; every phase boundary drains the block
    for (int p = 0; p < RandomPhases; p++) begin
      apply_setting(pick_size(), pick_size(), logic'($urandom_range(0, 1)),
                    logic'($urandom_range(0, 1)));
      nr = (rows_cfg == 0) ? 1 : (rows_cfg > MaxRows) ? MaxRows : int'(rows_cfg);
      nc = (cols_cfg == 0) ? 1 : (cols_cfg > MaxCols) ? MaxCols : int'(cols_cfg);
      // one phase holds the result side off long enough to back up the input
      if (p == 2) long_hold_req = 1'b1;
      // last phase runs at full rate on both sides
      if (p == RandomPhases - 1) quiet = 1'b1;
      for (int k = 0; k < ItemsPerPhase; k++) begin
        func = (p == 2 || $urandom_range(0, 1) == 1) ? FuncQuery : FuncWrite;
        // mostly inside the grid in use near its edges, the rest past it
        r = RowW'(pick_coord(nr, int'(MaxRows)));
        c = ColW'(pick_coord(nc, int'(MaxCols)));
        deliver(func, r, c, logic'($urandom_range(0, 1)), Predicted, none);
      end
    end

    settle();
    $display("sent %0d transactions, checked %0d query results", items_sent, queries_checked);
    $display("covered %0d grid settings: both neighbourhoods, both edge modes, clamped sizes",
             settings_used);
    if (fail_count == 0) begin
      $display("grid_neighbour_count regression: pass");
    end else begin
      $display("grid_neighbour_count regression: fail");
    end
    $finish;
  end

endmodule
